[src/assert_macros.svh]
// Assertion macros shared by the executor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cle_pkg.sv]
// Types, codes and ALU helper for the load/ALU subset executor.
package cle_pkg;

    localparam int RegCount = 8;
    localparam int RegIdxW  = $clog2(RegCount);

    localparam logic [RegIdxW-1:0] R_B = 3'd0;
    localparam logic [RegIdxW-1:0] R_C = 3'd1;
    localparam logic [RegIdxW-1:0] R_D = 3'd2;
    localparam logic [RegIdxW-1:0] R_E = 3'd3;
    localparam logic [RegIdxW-1:0] R_H = 3'd4;
    localparam logic [RegIdxW-1:0] R_L = 3'd5;
    localparam logic [RegIdxW-1:0] R_F = 3'd6;
    localparam logic [RegIdxW-1:0] R_A = 3'd7;

    // operand code that means (HL) in the opcode fields
    localparam logic [2:0] SRC_HL = 3'd6;

    localparam logic [7:0]  OP_HALT    = 8'h76;
    localparam logic [7:0]  OP_LD_HL_D8 = 8'h36;
    localparam logic [15:0] IO_PAGE    = 16'hFF00;

    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_AND = 3'd4;
    localparam logic [2:0] ALU_XOR = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_OPCODE   = 3'd1,
        PH_D8       = 3'd2,
        PH_D16_LOW  = 3'd3,
        PH_D16_HIGH = 3'd4,
        PH_DATA     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ACC_OPCODE = 2'd0,
        ACC_IMM    = 2'd1,
        ACC_READ   = 2'd2,
        ACC_WRITE  = 2'd3
    } access_t;

    typedef struct packed {
        logic [RegCount-1:0][7:0] rf;
        logic [15:0]              sp;
        logic [15:0]              pc;
        phase_t                   phase;
        logic [7:0]               op;
        logic [7:0]               imm_lo;
    } cpu_state_t;

    typedef struct packed {
        logic [15:0] bus_address;
        logic        bus_write;
        logic [7:0]  write_data;
        access_t     access_kind;
        logic [7:0]  accumulator;
        logic [7:0]  flag_bits;
    } bus_req_t;

    function automatic logic is_alu(input logic [7:0] op);
        return (op[7:3] == 5'b10000) || (op >= 8'hA0 && op <= 8'hB7);
    endfunction

    // returns {result, flags}
    function automatic logic [15:0] alu_op(input logic [2:0] sel,
                                           input logic [7:0] a,
                                           input logic [7:0] b);
        logic [8:0] sum;
        logic [4:0] half;
        logic [7:0] r;
        logic [7:0] f;
        sum  = {1'b0, a} + {1'b0, b};
        half = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        f    = 8'h00;
        case (sel)
            ALU_ADD:
            begin
                r    = sum[7:0];
                f[5] = half[4];
                f[4] = sum[8];
            end
            ALU_AND:
            begin
                r    = a & b;
                f[5] = 1'b1;
            end
            ALU_XOR: r = a ^ b;
            default: r = a | b;
        endcase
        f[7] = (r == 8'h00);
        return {r, f};
    endfunction

endpackage

[src/cpu_load_alu_subset_executor_core.sv]
// Top level: input register, single-pass executor, output register.
// Each accepted item yields the next bus access via the input, then the output register; one item
// per cycle is sustained unless out_stall holds. The input register feeds the execute logic, whose
// result and the CPU state are registered on the same edge; in_stall rises only when the output
// register is full and stalled. A read-data item while idle produces no access.
`include "assert_macros.svh"

module cpu_load_alu_subset_executor_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [7:0]            read_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           bus_address,
    output logic                  bus_write,
    output logic [7:0]            write_data,
    output logic [1:0]            access_kind,
    output logic [7:0]            accumulator,
    output logic [7:0]            flag_bits
);
    import cle_pkg::*;

    logic       in_v_reg;
    logic       func_reg;
    logic [7:0] rd_reg;
    cpu_state_t st_reg;
    cpu_state_t st_next;
    bus_req_t   req_next;
    bus_req_t   out_reg;
    logic       out_v_reg;
    logic       has_req;
    logic       adv;

    cle_exec u_exec (
        .st        (st_reg),
        .func      (func_reg),
        .read_data (rd_reg),
        .ns        (st_next),
        .req       (req_next),
        .has_req   (has_req)
    );

    assign adv      = !out_v_reg || !out_stall;
    assign in_stall = in_v_reg && !adv;

    // all-zero state puts the phase at idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
            st_reg         <= '0;
        end
        else
        begin
            if (!in_stall)
                in_v_reg <= in_valid;
            if (adv)
            begin
                out_v_reg <= in_v_reg && has_req;
                if (in_v_reg)
                    st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            func_reg <= func;
            rd_reg   <= read_data;
        end
        if (adv && in_v_reg && has_req)
            out_reg <= req_next;
    end

    assign out_valid   = out_v_reg;
    assign bus_address = out_reg.bus_address;
    assign bus_write   = out_reg.bus_write;
    assign write_data  = out_reg.write_data;
    assign access_kind = out_reg.access_kind;
    assign accumulator = out_reg.accumulator;
    assign flag_bits   = out_reg.flag_bits;

    `CLE_ASSERT_NEXT(a_write_idles, adv && in_v_reg && has_req && req_next.bus_write,
        st_reg.phase == PH_IDLE, "write access did not leave the core idle")
    `CLE_ASSERT_NOW(a_write_kind, out_v_reg,
        bus_write == (access_kind == ACC_WRITE), "bus_write disagrees with access kind")
    `CLE_ASSERT_NOW(a_flag_low, out_v_reg, flag_bits[3:0] == 4'h0,
        "low flag nibble not zero")
    `CLE_ASSERT_NOW(a_acc_match, out_v_reg && !in_v_reg, accumulator == st_reg.rf[R_A],
        "shown accumulator differs from register A")

endmodule

[src/cle_exec.sv]
// Single-pass decode and execute: next state and bus request for one item.
module cle_exec (
    input  cle_pkg::cpu_state_t st,
    input  logic                func,
    input  logic [7:0]          read_data,
    output cle_pkg::cpu_state_t ns,
    output cle_pkg::bus_req_t   req,
    output logic                has_req
);
    import cle_pkg::*;

    logic [15:0] hl;
    logic [15:0] bc;
    logic [15:0] de;
    logic [7:0]  op;
    logic [2:0]  dst;
    logic [2:0]  src;
    logic [15:0] alu_res;
    logic [15:0] imm16;
    logic [1:0]  psel;

    always_comb
    begin
        ns      = st;
        has_req = 1'b1;
        req     = '0;
        hl      = {st.rf[R_H], st.rf[R_L]};
        bc      = {st.rf[R_B], st.rf[R_C]};
        de      = {st.rf[R_D], st.rf[R_E]};
        op      = (st.phase == PH_OPCODE) ? read_data : st.op;
        dst     = op[5:3];
        src     = op[2:0];
        alu_res = '0;
        imm16   = {read_data, st.imm_lo};
        psel    = op[5:4];

        // default action is the next opcode fetch
        req.bus_address = st.pc;
        req.access_kind = ACC_OPCODE;
        ns.pc           = st.pc + 16'd1;
        ns.phase        = PH_OPCODE;

        if (func)
        begin
            case (st.phase)
                PH_OPCODE:
                begin
                    ns.op = read_data;
                    if ((op & 8'hCF) == 8'h01)
                    begin
                        req.access_kind = ACC_IMM;
                        ns.phase        = PH_D16_LOW;
                    end
                    else if ((op & 8'hC7) == 8'h06)
                    begin
                        req.access_kind = ACC_IMM;
                        ns.phase        = PH_D8;
                    end
                    else if (op == 8'h02 || op == 8'h12 || op == 8'h22 || op == 8'h32 ||
                             op == 8'hE2)
                    begin
                        ns.pc           = st.pc;
                        ns.phase        = PH_IDLE;
                        req.access_kind = ACC_WRITE;
                        req.bus_write   = 1'b1;
                        req.write_data  = st.rf[R_A];
                        case (op[5:4])
                            2'd0:    req.bus_address = bc;
                            2'd1:    req.bus_address = de;
                            default: req.bus_address = hl;
                        endcase
                        if (op == 8'hE2)
                            req.bus_address = IO_PAGE + {8'h00, st.rf[R_C]};
                        if (op == 8'h22)
                            {ns.rf[R_H], ns.rf[R_L]} = hl + 16'd1;
                        if (op == 8'h32)
                            {ns.rf[R_H], ns.rf[R_L]} = hl - 16'd1;
                    end
                    else if (op == 8'h0A || op == 8'h1A || op == 8'h2A || op == 8'h3A)
                    begin
                        ns.pc           = st.pc;
                        ns.phase        = PH_DATA;
                        req.access_kind = ACC_READ;
                        case (op[5:4])
                            2'd0:    req.bus_address = bc;
                            2'd1:    req.bus_address = de;
                            default: req.bus_address = hl;
                        endcase
                        if (op == 8'h2A)
                            {ns.rf[R_H], ns.rf[R_L]} = hl + 16'd1;
                        if (op == 8'h3A)
                            {ns.rf[R_H], ns.rf[R_L]} = hl - 16'd1;
                    end
                    else if ((op[7:6] == 2'b01 && op != OP_HALT) || is_alu(op))
                    begin
                        if (src == SRC_HL)
                        begin
                            ns.pc           = st.pc;
                            ns.phase        = PH_DATA;
                            req.access_kind = ACC_READ;
                            req.bus_address = hl;
                        end
                        else if (op[7:6] == 2'b01 && dst == SRC_HL)
                        begin
                            ns.pc           = st.pc;
                            ns.phase        = PH_IDLE;
                            req.access_kind = ACC_WRITE;
                            req.bus_address = hl;
                            req.bus_write   = 1'b1;
                            req.write_data  = st.rf[src];
                        end
                        else if (op[7:6] == 2'b01)
                            ns.rf[dst] = st.rf[src];
                        else
                        begin
                            alu_res     = alu_op(dst, st.rf[R_A], st.rf[src]);
                            ns.rf[R_A]  = alu_res[15:8];
                            ns.rf[R_F]  = alu_res[7:0];
                        end
                    end
                end
                PH_D8:
                begin
                    if (st.op == OP_LD_HL_D8)
                    begin
                        ns.pc           = st.pc;
                        ns.phase        = PH_IDLE;
                        req.access_kind = ACC_WRITE;
                        req.bus_address = hl;
                        req.bus_write   = 1'b1;
                        req.write_data  = read_data;
                    end
                    else
                        ns.rf[dst] = read_data;
                end
                PH_D16_LOW:
                begin
                    ns.imm_lo       = read_data;
                    req.access_kind = ACC_IMM;
                    ns.phase        = PH_D16_HIGH;
                end
                PH_D16_HIGH:
                begin
                    case (psel)
                        2'd0:    {ns.rf[R_B], ns.rf[R_C]} = imm16;
                        2'd1:    {ns.rf[R_D], ns.rf[R_E]} = imm16;
                        2'd2:    {ns.rf[R_H], ns.rf[R_L]} = imm16;
                        default: ns.sp = imm16;
                    endcase
                end
                PH_DATA:
                begin
                    if (is_alu(st.op))
                    begin
                        alu_res    = alu_op(dst, st.rf[R_A], read_data);
                        ns.rf[R_A] = alu_res[15:8];
                        ns.rf[R_F] = alu_res[7:0];
                    end
                    else if (st.op[7:6] == 2'b01)
                        ns.rf[dst] = read_data;
                    else
                        ns.rf[R_A] = read_data;
                end
                default:
                begin
                    // read data while idle is dropped
                    ns      = st;
                    has_req = 1'b0;
                end
            endcase
        end

        req.accumulator = ns.rf[R_A];
        req.flag_bits   = ns.rf[R_F];
    end

endmodule
